@@ src/gfcpg_pkg.sv @@
// Shared types, constants and a helper function for the GBM fine/coarse path generator.
package gfcpg_pkg;

  // Level limit and Taylor series length of the exp unit
  localparam logic [4:0] MAX_LEVEL = 5'd16;
  localparam logic [3:0] EXP_TERMS = 4'd12;

  // Fixed-point constants of the exp unit (Q.30)
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_PRICE = 3'd0,
    REG_DRIFT         = 3'd1,
    REG_DIFFUSION     = 3'd2,
    REG_LEVEL         = 3'd3,
    REG_PATHS         = 3'd4
  } gfcpg_reg_t;

  // Configuration register file contents
  typedef struct packed {
    logic [31:0]        initial_price;
    logic signed [31:0] drift_per_step;
    logic [30:0]        diffusion_per_step;
    logic [4:0]         level_log2_steps;
    logic [15:0]        paths_in_batch;
  } gfcpg_cfg_t;

  // One classified step handed from front to back
  typedef struct packed {
    logic signed [31:0] fine_log;
    logic signed [31:0] coarse_log;
    logic               coarse_valid;
    logic               path_end;
    logic               batch_end;
  } gfcpg_item_t;

  // floor(2^32 / n) for n = 1..12; n = 1 uses all ones, fixed by the remainder step
  function automatic logic [31:0] gfcpg_recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

@@ src/gfcpg_front.sv @@
// Front end: takes normal samples, updates fine/coarse log sums and path counters.
module gfcpg_front import gfcpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] normal_sample,
  input  gfcpg_cfg_t         cfg,
  input  logic               q_full,
  output logic               q_push,
  output gfcpg_item_t        q_item
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_ADD  = 2'b10
  } fstate_t;

  fstate_t            state;
  logic signed [31:0] fine_sum;
  logic signed [31:0] coarse_sum;
  logic signed [15:0] pair_first;
  logic [16:0]        step_index;
  logic [15:0]        path_index;
  logic signed [15:0] sample;
  logic signed [47:0] prod_f;
  logic signed [48:0] prod_c;

  logic               accept;
  logic signed [16:0] pair_sum;
  logic [4:0]         lvl;
  logic [17:0]        steps;
  logic [15:0]        paths;
  logic               second, pend, bend;
  logic signed [47:0] rnd_f;
  logic signed [48:0] rnd_c;
  logic signed [39:0] sum_f, sum_c;
  logic signed [31:0] sat_f, sat_c;

  // Clamp a wide sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign full   = (state != F_IDLE) || q_full;
  assign accept = push && !full;
  assign pair_sum = 17'(pair_first) + 17'(normal_sample);

  // Step count and end-of-path / end-of-batch decode
  always_comb begin
    lvl = cfg.level_log2_steps;
    if (lvl == 5'd0) begin
      lvl = 5'd1;
    end else if (lvl > MAX_LEVEL) begin
      lvl = MAX_LEVEL;
    end
    steps  = 18'd1 << lvl;
    paths  = (cfg.paths_in_batch == 16'd0) ? 16'd1 : cfg.paths_in_batch;
    second = step_index[0];
    pend   = (18'(step_index) + 18'd1) >= steps;
    bend   = pend && ((17'(path_index) + 17'd1) >= 17'(paths));
  end

  // Rounded diffusion terms plus drift, saturated into the sums
  always_comb begin
    rnd_f = (prod_f + 48'sd2048) >>> 12;
    rnd_c = (prod_c + 49'sd2048) >>> 12;
    sum_f = 40'(fine_sum) + 40'(cfg.drift_per_step) + 40'(rnd_f);
    sum_c = 40'(coarse_sum) + (40'(cfg.drift_per_step) <<< 1) + 40'(rnd_c);
    sat_f = sat32(sum_f);
    sat_c = sat32(sum_c);
  end

  assign q_push              = (state == F_ADD);
  assign q_item.fine_log     = sat_f;
  assign q_item.coarse_log   = sat_c;
  assign q_item.coarse_valid = second;
  assign q_item.path_end     = pend;
  assign q_item.batch_end    = bend;

  // Control and products
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (accept) state <= F_ADD;
        F_ADD:  state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
    if (accept) begin
      sample <= normal_sample;
      prod_f <= $signed({1'b0, cfg.diffusion_per_step}) * normal_sample;
      prod_c <= $signed({1'b0, cfg.diffusion_per_step}) * pair_sum;
    end
  end

  // Path state
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_sum   <= '0;
      coarse_sum <= '0;
      pair_first <= '0;
      step_index <= '0;
      path_index <= '0;
    end else if (state == F_ADD) begin
      if (pend) begin
        fine_sum   <= '0;
        coarse_sum <= '0;
        pair_first <= '0;
        step_index <= '0;
        path_index <= bend ? 16'd0 : path_index + 16'd1;
      end else begin
        fine_sum   <= sat_f;
        step_index <= step_index + 17'd1;
        if (second) begin
          coarse_sum <= sat_c;
        end else begin
          pair_first <= sample;
        end
      end
    end
  end

  // A step beat always finishes in the cycle after its accept
  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == F_ADD) |=> (state == F_IDLE))
    else $error("front stayed in add state");

endmodule

@@ src/gfcpg_queue.sv @@
// Short queue of classified steps between front and back.
module gfcpg_queue import gfcpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  gfcpg_item_t wr_item,
  output logic        q_full,
  input  logic        rd_en,
  output gfcpg_item_t rd_item,
  output logic        q_empty
);

  gfcpg_item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]       cnt;

  assign q_full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt == '0);
  assign rd_item = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && q_full && !rd_en))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && q_empty))
    else $error("queue read while empty");

endmodule

@@ src/gfcpg_back.sv @@
// Back end: iterative exp unit that turns log sums into saturated prices.
module gfcpg_back import gfcpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gfcpg_cfg_t  cfg,
  input  logic        q_empty,
  input  gfcpg_item_t q_item,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] fine_price,
  output logic [31:0] coarse_price,
  output logic        coarse_valid,
  output logic        path_end,
  output logic        batch_end
);

  typedef enum logic [10:0] {
    B_IDLE = 11'b000_0000_0001,
    B_LOG  = 11'b000_0000_0010,
    B_FRAC = 11'b000_0000_0100,
    B_X    = 11'b000_0000_1000,
    B_T1   = 11'b000_0001_0000,
    B_T2   = 11'b000_0010_0000,
    B_T3   = 11'b000_0100_0000,
    B_SC   = 11'b000_1000_0000,
    B_RND  = 11'b001_0000_0000,
    B_SH   = 11'b010_0000_0000,
    B_OUT  = 11'b100_0000_0000
  } bstate_t;

  bstate_t            state;
  gfcpg_item_t        item;
  logic               phase_coarse;
  logic signed [31:0] l_cur;
  logic signed [63:0] y_prod;
  logic signed [9:0]  k;
  logic [59:0]        f_prod;
  logic [29:0]        x;
  logic [30:0]        term;
  logic [31:0]        m_sum;
  logic [3:0]         n;
  logic [60:0]        t_prod;
  logic [30:0]        v;
  logic [62:0]        d_prod;
  logic [63:0]        s_prod;
  logic signed [10:0] sh;
  logic [64:0]        rnd;
  logic [31:0]        fine_res, coarse_res;
  logic               out_valid;

  logic signed [63:0] y;
  logic [30:0]        q0, q;
  logic [34:0]        rem;
  logic [64:0]        shifted;
  logic [31:0]        res;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !out_valid;

  // Series term divide: reciprocal estimate plus one correction
  always_comb begin
    y   = y_prod >>> 24;
    q0  = d_prod[62:32];
    rem = 35'(v) - 35'(q0 * n);
    q   = (rem >= 35'(n)) ? q0 + 31'd1 : q0;
  end

  // Final scaling with round half up and saturation
  always_comb begin
    shifted = rnd >> sh[5:0];
    if (sh <= 11'sd0) begin
      res = (s_prod != 64'd0) ? 32'hFFFF_FFFF : 32'd0;
    end else if (sh >= 11'sd64) begin
      res = 32'd0;
    end else if (shifted[64:32] != '0) begin
      res = 32'hFFFF_FFFF;
    end else begin
      res = shifted[31:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished beat, or clear once it is taken
      if (state == B_OUT && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: if (!q_empty) state <= B_LOG;
        B_LOG:  state <= B_FRAC;
        B_FRAC: state <= B_X;
        B_X:    state <= B_T1;
        B_T1:   state <= B_T2;
        B_T2:   state <= B_T3;
        B_T3:   state <= (n == EXP_TERMS) ? B_SC : B_T1;
        B_SC:   state <= B_RND;
        B_RND:  state <= B_SH;
        B_SH:   state <= (!phase_coarse && item.coarse_valid) ? B_LOG : B_OUT;
        B_OUT: begin
          if (!out_valid || pop) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item         <= q_item;
        l_cur        <= q_item.fine_log;
        phase_coarse <= 1'b0;
      end
      B_LOG:  y_prod <= l_cur * LOG2E_Q30;
      B_FRAC: begin
        k      <= y[39:30];
        f_prod <= y[29:0] * LN2_Q30;
      end
      B_X: begin
        x     <= f_prod[59:30];
        term  <= ONE_Q30;
        m_sum <= 32'(ONE_Q30);
        n     <= 4'd1;
      end
      B_T1:   t_prod <= term * x;
      B_T2: begin
        v      <= t_prod[60:30];
        d_prod <= t_prod[60:30] * gfcpg_recip(n);
      end
      B_T3: begin
        term  <= q;
        m_sum <= m_sum + 32'(q);
        n     <= n + 4'd1;
      end
      B_SC: begin
        s_prod <= cfg.initial_price * m_sum;
        sh     <= 11'sd30 - 11'(k);
      end
      B_RND: rnd <= 65'(s_prod) + (65'd1 << 6'(sh - 11'sd1));
      B_SH: begin
        if (!phase_coarse) begin
          fine_res   <= res;
          coarse_res <= 32'd0;
          if (item.coarse_valid) begin
            phase_coarse <= 1'b1;
            l_cur        <= item.coarse_log;
          end
        end else begin
          coarse_res <= res;
        end
      end
      B_OUT: begin
        if (!out_valid || pop) begin
          fine_price   <= fine_res;
          coarse_price <= coarse_res;
          coarse_valid <= item.coarse_valid;
          path_end     <= item.path_end;
          batch_end    <= item.batch_end;
        end
      end
      default: ;
    endcase
  end

  a_series_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_T3 && n == EXP_TERMS) |=> (state == B_SC))
    else $error("series did not stop after last term");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_LOG))
    else $error("step taken from queue without starting exp");

endmodule

@@ src/gbm_fine_coarse_path_generator.sv @@
// Top level: GBM fine/coarse coupled path generator with its configuration registers.
//
// Usage:
//   Input channel: push a signed Q3.12 normal sample on normal_sample while full is low.
//   Result channel: while empty is low the oldest result sits on fine_price,
//   coarse_price, coarse_valid, path_end and batch_end; pop takes the beat.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high and a write takes effect on the next step. Write only while idle.
// Data flow:
//   The front takes one sample at a time (multiply, then sum update), then the step
//   waits in a 2-entry queue. The back's exp unit runs the 12 Taylor terms in turn
//   (multiply, divide, accumulate), with log/fraction setup before and scaling after.
//   A step with a coarse price runs the exp unit twice, fine then coarse; the back
//   pops no new step until it is done, and its exp loop sets the sustained rate.
// Reset:
//   rst (synchronous, active high) restores the register defaults, clears the
//   log sums and path/step counters and empties the queue and output register.
// Stall:
//   If pop stays low the back holds its finished result, the queue fills, and
//   full rises; no beat is lost.
module gbm_fine_coarse_path_generator import gfcpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   normal_sample,
  input  logic                 pop,
  output logic                 empty,
  output logic [31:0]          fine_price,
  output logic [31:0]          coarse_price,
  output logic                 coarse_valid,
  output logic                 path_end,
  output logic                 batch_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  gfcpg_cfg_t  cfg;
  logic        q_full, q_empty, q_push, q_pop;
  gfcpg_item_t q_wr_item, q_rd_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_price      <= 32'd6553600;
      cfg.drift_per_step     <= '0;
      cfg.diffusion_per_step <= '0;
      cfg.level_log2_steps   <= 5'd1;
      cfg.paths_in_batch     <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INITIAL_PRICE: cfg.initial_price      <= cfg_data;
        REG_DRIFT:         cfg.drift_per_step     <= cfg_data;
        REG_DIFFUSION:     cfg.diffusion_per_step <= cfg_data[30:0];
        REG_LEVEL:         cfg.level_log2_steps   <= cfg_data[4:0];
        REG_PATHS:         cfg.paths_in_batch     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gfcpg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .normal_sample (normal_sample),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_wr_item)
  );

  gfcpg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .q_empty (q_empty)
  );

  gfcpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .fine_price   (fine_price),
    .coarse_price (coarse_price),
    .coarse_valid (coarse_valid),
    .path_end     (path_end),
    .batch_end    (batch_end)
  );

endmodule
